// ===== sv/clamped_pid_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Clamped PID controller assertion macros
// Shared property wrappers, clocked on i_clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_PID_CONTROLLER_MACROS_SVH
`define CLAMPED_PID_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Clamped PID controller package
// Widths, register indexes, stage payload types and the term clamp.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int SUM_WIDTH  = 32;
    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 15;
    localparam int CFG_IDX_W  = 2;

    localparam int FULL_SCALE = 100 << FRAC_BITS;
    localparam int FS_W       = $clog2(FULL_SCALE + 1);
    localparam int DIFF_W     = DATA_W + 1;
    localparam int P_W        = GAIN_W + DATA_W;
    localparam int I_W        = GAIN_W + SUM_WIDTH;
    localparam int D_W        = GAIN_W + DIFF_W;
    localparam int PROD_W     = I_W;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;
    localparam int TOT_W      = FS_W + 2;

    localparam logic [FS_W-1:0] FS_VAL = FS_W'(FULL_SCALE);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_GAIN = 2'd0,
        CFG_I_GAIN = 2'd1,
        CFG_D_GAIN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] p;
        logic signed [GAIN_W-1:0] i;
        logic signed [GAIN_W-1:0] d;
    } t_gains;

    typedef struct packed {
        logic                        bad;
        logic signed [DATA_W-1:0]    err;
        logic signed [SUM_WIDTH-1:0] sum;
        logic signed [DIFF_W-1:0]    diff;
    } t_front;

    typedef struct packed {
        logic                 bad;
        logic signed [P_W-1:0] p;
        logic signed [I_W-1:0] i;
        logic signed [D_W-1:0] d;
    } t_prod;

    // Floor shift by FRAC_BITS, clamp to 0..full scale.
    function automatic logic [FS_W-1:0] term(input logic signed [PROD_W-1:0] prod);
        logic [SHIFT_W-1:0] t;
        t = prod[PROD_W-1:FRAC_BITS];
        if (prod[PROD_W-1] || (prod == '0)) begin
            term = '0;
        end else if (t > SHIFT_W'(FULL_SCALE)) begin
            term = FS_VAL;
        end else begin
            term = t[FS_W-1:0];
        end
    endfunction

endpackage

// ===== sv/clamped_pid_controller.sv =====
// ----------------------------------------------------------------------------
// Clamped PID controller
// Input beat: setpoint and measured value, percent with 8 fraction bits.
// Output beat: drive clamped to 0..100 % and a range error flag.
// Both channels are valid/ready; gains are written on the cfg port
// (index 0 p_gain, 1 i_gain, 2 d_gain); the user must write them only
// while no beat is in flight; the block does not enforce this. Pipeline:
// input register, error/integral stage, multiply stage, result register.
// One beat is taken every cycle unless the receiver stalls. The integral
// update is a single saturating add, so consecutive beats need no spacing.
// A beat with either value outside 0..100 % gives drive 0, flag 1 and
// leaves the integral and previous error untouched.
// Reset clears gains, integral, previous error and all valid flags.
// When the receiver stalls, the result register holds its beat and the
// stages behind it keep filling; o_ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module clamped_pid_controller import cpc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_setpoint,
    input  logic signed [DATA_W-1:0] i_measured,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [DRIVE_W-1:0]       o_drive,
    output logic                     o_range_error,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [GAIN_W-1:0]        i_cfg_data
);

    t_gains r_gains;
    logic   a_valid;
    logic   a_ready;
    t_front a_data;
    logic   b_valid;
    logic   b_ready;
    t_prod  b_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_P_GAIN: r_gains.p <= $signed(i_cfg_data);
                CFG_I_GAIN: r_gains.i <= $signed(i_cfg_data);
                CFG_D_GAIN: r_gains.d <= $signed(i_cfg_data);
                default:    r_gains   <= r_gains;
            endcase
        end
    end

    cpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_setpoint (i_setpoint),
        .i_measured (i_measured),
        .o_a_valid  (a_valid),
        .o_a        (a_data),
        .i_a_ready  (a_ready)
    );

    cpc_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gains   (r_gains),
        .i_a_valid (a_valid),
        .o_a_ready (a_ready),
        .i_a       (a_data),
        .o_b_valid (b_valid),
        .o_b       (b_data),
        .i_b_ready (b_ready)
    );

    cpc_clamp u_clamp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_b_valid     (b_valid),
        .o_b_ready     (b_ready),
        .i_b           (b_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_drive       (o_drive),
        .o_range_error (o_range_error)
    );

endmodule

// ===== sv/cpc_front.sv =====
// ----------------------------------------------------------------------------
// Clamped PID controller front stage
// Input register, range check, error, saturating integral and difference.
// ----------------------------------------------------------------------------
`include "clamped_pid_controller_macros.svh"

module cpc_front import cpc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_setpoint,
    input  logic signed [DATA_W-1:0] i_measured,
    output logic                     o_a_valid,
    output t_front                   o_a,
    input  logic                     i_a_ready
);

    localparam int                   EXT_W   = SUM_WIDTH + 1;
    localparam logic [31:0]          FS_32   = 32'(FULL_SCALE);
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic                        r_in_valid;
    logic signed [DATA_W-1:0]    r_sp;
    logic signed [DATA_W-1:0]    r_mv;
    logic                        r_a_valid;
    t_front                      r_a;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [DATA_W-1:0]    r_last;

    logic                        a_load;
    logic                        a_take;
    t_front                      n_a;
    logic signed [EXT_W-1:0]     sum_ext;
    logic signed [SUM_WIDTH-1:0] n_sum;

    assign a_load  = !r_a_valid || i_a_ready;
    assign a_take  = a_load && r_in_valid;
    assign o_ready = !r_in_valid || a_load;

    always_comb begin
        n_a.bad = r_sp[DATA_W-1] || r_mv[DATA_W-1]
               || (32'(r_sp[DATA_W-2:0]) > FS_32)
               || (32'(r_mv[DATA_W-2:0]) > FS_32);
        n_a.err = r_sp - r_mv;
        sum_ext = {r_sum[SUM_WIDTH-1], r_sum} + EXT_W'(n_a.err);
        if (sum_ext[EXT_W-1] != sum_ext[EXT_W-2]) begin
            n_sum = sum_ext[EXT_W-1] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = sum_ext[SUM_WIDTH-1:0];
        end
        n_a.sum  = n_sum;
        n_a.diff = DIFF_W'(n_a.err) - DIFF_W'(r_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_a_valid  <= 1'b0;
            r_sum      <= '0;
            r_last     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (a_load) begin
                r_a_valid <= r_in_valid;
            end
            if (a_take && !n_a.bad) begin
                r_sum  <= n_sum;
                r_last <= n_a.err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sp <= i_setpoint;
            r_mv <= i_measured;
        end
        if (a_load) begin
            r_a <= n_a;
        end
    end

    assign o_a_valid = r_a_valid;
    assign o_a       = r_a;

    `CPC_ASSERT_NEXT(a_bad_holds_state, a_take && n_a.bad,
        $stable(r_sum) && $stable(r_last), "integral state moved on an out-of-range beat")
    `CPC_ASSERT_NEXT(a_idle_holds_state, !a_take,
        $stable(r_sum) && $stable(r_last), "integral state moved without a beat")
    `CPC_ASSERT_NEXT(a_sum_forwarded, a_take && !n_a.bad,
        r_a_valid && (r_a.sum == r_sum), "stage sum differs from integral state")

endmodule

// ===== sv/cpc_mult.sv =====
// ----------------------------------------------------------------------------
// Clamped PID controller multiply stage
// Registered products of the three gains with error, integral and difference.
// ----------------------------------------------------------------------------
module cpc_mult import cpc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_gains i_gains,
    input  logic   i_a_valid,
    output logic   o_a_ready,
    input  t_front i_a,
    output logic   o_b_valid,
    output t_prod  o_b,
    input  logic   i_b_ready
);

    logic  r_b_valid;
    t_prod r_b;
    logic  b_load;
    t_prod n_b;

    assign b_load    = !r_b_valid || i_b_ready;
    assign o_a_ready = b_load;

    always_comb begin
        n_b.bad = i_a.bad;
        n_b.p   = P_W'(i_gains.p) * P_W'(i_a.err);
        n_b.i   = I_W'(i_gains.i) * I_W'(i_a.sum);
        n_b.d   = D_W'(i_gains.d) * D_W'(i_a.diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= i_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b <= n_b;
        end
    end

    assign o_b_valid = r_b_valid;
    assign o_b       = r_b;

endmodule

// ===== sv/cpc_clamp.sv =====
// ----------------------------------------------------------------------------
// Clamped PID controller output stage
// Term clamps, clamped sum and the result register.
// ----------------------------------------------------------------------------
`include "clamped_pid_controller_macros.svh"

module cpc_clamp import cpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_b_valid,
    output logic               o_b_ready,
    input  t_prod              i_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DRIVE_W-1:0] o_drive,
    output logic               o_range_error
);

    logic               r_out_valid;
    logic [DRIVE_W-1:0] r_drive;
    logic               r_range_error;

    logic               out_load;
    logic [FS_W-1:0]    tp;
    logic [FS_W-1:0]    ti;
    logic [FS_W-1:0]    td;
    logic [TOT_W-1:0]   total;
    logic [DRIVE_W-1:0] n_drive;

    assign out_load  = !r_out_valid || i_ready;
    assign o_b_ready = out_load;

    always_comb begin
        tp    = term(PROD_W'(i_b.p));
        ti    = term(PROD_W'(i_b.i));
        td    = term(PROD_W'(i_b.d));
        total = TOT_W'(tp) + TOT_W'(ti) + TOT_W'(td);
        if (i_b.bad) begin
            n_drive = '0;
        end else if (total > TOT_W'(FS_VAL)) begin
            n_drive = DRIVE_W'(FS_VAL);
        end else begin
            n_drive = DRIVE_W'(total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= i_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_drive       <= n_drive;
            r_range_error <= i_b.bad;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_drive       = r_drive;
    assign o_range_error = r_range_error;

    `CPC_ASSERT_NOW(out_bad_zero, r_out_valid && r_range_error,
        r_drive == '0, "range error beat with nonzero drive")

endmodule
